/* rtl/arfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adapter response frame parser package
// Frame constants, status codes and the command that passes from the byte
// parser to the telemetry update stage.
// ----------------------------------------------------------------------------
package arfp_pkg;

    localparam int CHANNELS      = 4;
    localparam int ADC_WORDS     = 2;
    localparam int PAYLOAD_DEPTH = 2 * CHANNELS + 2 * ADC_WORDS;
    localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_DEPTH);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0]  HEADER_BYTE    = 8'h55;
    localparam logic [7:0]  TYPE_ACK       = 8'h01;
    localparam logic [7:0]  TYPE_PARSE_ERR = 8'h02;
    localparam logic [7:0]  TYPE_PARAM_ERR = 8'h03;
    localparam logic [7:0]  TYPE_TELEMETRY = 8'h10;
    localparam logic [7:0]  TYPE_CONFIG    = 8'hcf;
    localparam logic [15:0] PERIOD_FAIL    = 16'hff00;

    localparam logic [4:0] LEN_SHORT     = 5'd3;
    localparam logic [4:0] LEN_TELEMETRY = 5'd15;
    localparam logic [4:0] LEN_CONFIG    = 5'd23;

    typedef enum logic [2:0] {
        ST_ACK_OK         = 3'd0,
        ST_TELEMETRY      = 3'd1,
        ST_CONFIG_IGNORED = 3'd2,
        ST_REJECTED       = 3'd3,
        ST_CHECKSUM_ERR   = 3'd4,
        ST_UNKNOWN_TYPE   = 3'd5
    } frame_status_t;

    typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_t;

    typedef struct packed {
        frame_status_t status;
        payload_t      payload;
    } frame_cmd_t;

endpackage

/* rtl/arfp_rx_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Received byte channel
// Carries one UART byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface arfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/arfp_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame result channel
// Carries one frame result per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface arfp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [15:0] period_ch0;
    logic [15:0] period_ch1;
    logic [15:0] period_ch2;
    logic [15:0] period_ch3;
    logic [3:0]  valid_mask;
    logic [15:0] adc_first;
    logic [15:0] adc_second;
    logic [15:0] errors_ch0;
    logic [15:0] errors_ch1;
    logic [15:0] errors_ch2;
    logic [15:0] errors_ch3;

    modport source (
        output valid, output frame_status,
        output period_ch0, output period_ch1, output period_ch2, output period_ch3,
        output valid_mask, output adc_first, output adc_second,
        output errors_ch0, output errors_ch1, output errors_ch2, output errors_ch3,
        input ready
    );
    modport sink (
        input valid, input frame_status,
        input period_ch0, input period_ch1, input period_ch2, input period_ch3,
        input valid_mask, input adc_first, input adc_second,
        input errors_ch0, input errors_ch1, input errors_ch2, input errors_ch3,
        output ready
    );
endinterface

/* rtl/arfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte parser
// Hunts for the header, tracks frame length and checksum, stores the
// payload and pushes one command per finished or dropped frame.
// ----------------------------------------------------------------------------
module arfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    arfp_rx_if.sink              rx,
    input  logic                 cmd_full,
    output logic                 cmd_push,
    output arfp_pkg::frame_cmd_t cmd_data
);
    import arfp_pkg::*;

    logic [4:0]    byte_count_reg, byte_count_next;
    logic [4:0]    expected_length_reg, expected_length_next;
    logic [7:0]    running_sum_reg, running_sum_next;
    logic [7:0]    response_type_reg, response_type_next;
    payload_t      payload_reg;

    logic          take;
    logic [7:0]    sum_plus;
    logic [5:0]    count_plus;
    logic [4:0]    pos;
    logic          store_en;
    frame_status_t status;

    assign rx.ready   = !cmd_full;
    assign take       = rx.valid && rx.ready;
    assign sum_plus   = running_sum_reg + rx.rx_byte;
    assign count_plus = {1'b0, byte_count_reg} + 6'd1;
    assign pos        = byte_count_reg - 5'd2;

    always_comb
    begin
        byte_count_next      = byte_count_reg;
        expected_length_next = expected_length_reg;
        running_sum_next     = running_sum_reg;
        response_type_next   = response_type_reg;
        store_en             = 1'b0;
        cmd_push             = 1'b0;
        status               = ST_ACK_OK;
        if (take)
        begin
            if (byte_count_reg == 5'd0)
            begin
                if (rx.rx_byte == HEADER_BYTE)
                begin
                    byte_count_next  = 5'd1;
                    running_sum_next = rx.rx_byte;
                end
            end
            else if (byte_count_reg == 5'd1)
            begin
                response_type_next = rx.rx_byte;
                running_sum_next   = sum_plus;
                byte_count_next    = 5'd2;
                unique case (rx.rx_byte) inside
                    TYPE_ACK, TYPE_PARSE_ERR, TYPE_PARAM_ERR:
                        expected_length_next = LEN_SHORT;
                    TYPE_TELEMETRY:
                        expected_length_next = LEN_TELEMETRY;
                    TYPE_CONFIG:
                        expected_length_next = LEN_CONFIG;
                    default:
                    begin
                        byte_count_next      = 5'd0;
                        expected_length_next = 5'd0;
                        cmd_push             = 1'b1;
                        status               = ST_UNKNOWN_TYPE;
                    end
                endcase
            end
            else if (count_plus < {1'b0, expected_length_reg})
            begin
                store_en         = (pos < 5'(PAYLOAD_DEPTH));
                running_sum_next = sum_plus;
                byte_count_next  = count_plus[4:0];
            end
            else
            begin
                cmd_push = 1'b1;
                if (rx.rx_byte != running_sum_reg)
                begin
                    status = ST_CHECKSUM_ERR;
                end
                else
                begin
                    unique case (response_type_reg)
                        TYPE_ACK:       status = ST_ACK_OK;
                        TYPE_TELEMETRY: status = ST_TELEMETRY;
                        TYPE_CONFIG:    status = ST_CONFIG_IGNORED;
                        default:        status = ST_REJECTED;
                    endcase
                end
                byte_count_next      = 5'd0;
                expected_length_next = 5'd0;
            end
        end
    end

    assign cmd_data.status  = status;
    assign cmd_data.payload = payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= 5'd0;
            expected_length_reg <= 5'd0;
            running_sum_reg     <= 8'd0;
            response_type_reg   <= 8'd0;
        end
        else
        begin
            byte_count_reg      <= byte_count_next;
            expected_length_reg <= expected_length_next;
            running_sum_reg     <= running_sum_next;
            response_type_reg   <= response_type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            payload_reg[pos[PAYLOAD_IDX_W-1:0]] <= rx.rx_byte;
        end
    end

endmodule

/* rtl/arfp_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame command queue
// Short first-in first-out buffer between the byte parser and the
// telemetry update stage.
// ----------------------------------------------------------------------------
module arfp_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  arfp_pkg::frame_cmd_t push_data,
    output logic                 full,
    input  logic                 pop,
    output arfp_pkg::frame_cmd_t pop_data,
    output logic                 empty
);
    import arfp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_cmd_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/arfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry update stage
// Applies good telemetry frames to the period, ADC, valid and error
// registers and presents one result item per frame command.
// ----------------------------------------------------------------------------
module arfp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  arfp_pkg::frame_cmd_t cmd_data,
    output logic                 cmd_pop,
    arfp_res_if.source           res
);
    import arfp_pkg::*;

    logic [15:0]         period_reg [CHANNELS];
    logic [15:0]         adc_reg [ADC_WORDS];
    logic [CHANNELS-1:0] valid_reg;
    logic [15:0]         error_reg [CHANNELS];
    frame_status_t       status_reg;
    logic                out_valid_reg;

    logic [15:0]         word_period [CHANNELS];
    logic [15:0]         word_adc [ADC_WORDS];
    logic [CHANNELS-1:0] usable;

    assign cmd_pop = cmd_valid && (!out_valid_reg || res.ready);

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            word_period[i] = {cmd_data.payload[2 * i + 1], cmd_data.payload[2 * i]};
            usable[i]      = (word_period[i] != 16'd0) && (word_period[i] < PERIOD_FAIL);
        end
        for (int j = 0; j < ADC_WORDS; j++)
        begin
            word_adc[j] = {cmd_data.payload[2 * CHANNELS + 2 * j + 1],
                           cmd_data.payload[2 * CHANNELS + 2 * j]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                period_reg[i] <= 16'd0;
                error_reg[i]  <= 16'd0;
            end
            for (int j = 0; j < ADC_WORDS; j++)
            begin
                adc_reg[j] <= 16'd0;
            end
        end
        else if (cmd_pop)
        begin
            out_valid_reg <= 1'b1;
            if (cmd_data.status == ST_TELEMETRY)
            begin
                valid_reg <= usable;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    period_reg[i] <= word_period[i];
                    if (!usable[i])
                    begin
                        error_reg[i] <= error_reg[i] + 16'd1;
                    end
                end
                for (int j = 0; j < ADC_WORDS; j++)
                begin
                    adc_reg[j] <= word_adc[j];
                end
            end
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            status_reg <= cmd_data.status;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.frame_status = status_reg;
    assign res.period_ch0   = period_reg[0];
    assign res.period_ch1   = period_reg[1];
    assign res.period_ch2   = period_reg[2];
    assign res.period_ch3   = period_reg[3];
    assign res.valid_mask   = valid_reg;
    assign res.adc_first    = adc_reg[0];
    assign res.adc_second   = adc_reg[1];
    assign res.errors_ch0   = error_reg[0];
    assign res.errors_ch1   = error_reg[1];
    assign res.errors_ch2   = error_reg[2];
    assign res.errors_ch3   = error_reg[3];

endmodule

/* rtl/adapter_response_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adapter response frame parser
// Parses framed replies from a serial motor-output adapter and reports
// frame status, telemetry periods, ADC words and per-channel error counts.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle while the command queue
// is not full. A byte that closes or drops a frame produces one result item:
// its command passes through the two-entry command queue behind the byte parser
// and then the result register of the telemetry update stage. All other
// bytes produce no result. When the result side stalls, the queue absorbs
// two frame commands before the byte input deasserts ready.
module adapter_response_frame_parser (
    input  logic       clk,
    input  logic       rst_n,
    arfp_rx_if.sink    rx,
    arfp_res_if.source res
);
    import arfp_pkg::*;

    logic       cmd_push;
    logic       cmd_full;
    logic       cmd_pop;
    logic       cmd_empty;
    frame_cmd_t cmd_in;
    frame_cmd_t cmd_out;

    arfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in)
    );

    arfp_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    arfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res       (res)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("Frame command pushed into a full queue.");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("Frame command popped from an empty queue.");

    a_mask_period: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |->
            (!res.valid_mask[0] || (res.period_ch0 != 16'd0 && res.period_ch0 < PERIOD_FAIL)) &&
            (!res.valid_mask[1] || (res.period_ch1 != 16'd0 && res.period_ch1 < PERIOD_FAIL)) &&
            (!res.valid_mask[2] || (res.period_ch2 != 16'd0 && res.period_ch2 < PERIOD_FAIL)) &&
            (!res.valid_mask[3] || (res.period_ch3 != 16'd0 && res.period_ch3 < PERIOD_FAIL)))
        else $error("Valid mask marks an unusable period.");

endmodule
